// ===== src/tesle_pkg.sv =====
package tesle_pkg;

  // Line capacity in columns; a line holds at most LINE_COLUMNS - 1 characters.
  localparam int unsigned LINE_COLUMNS = 256;
  localparam int unsigned CNT_W        = $clog2(LINE_COLUMNS);

  localparam logic [7:0] BYTE_BEL   = 8'h07;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_OSC   = 8'h5D;
  localparam logic [7:0] BYTE_BSL   = 8'h5C;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;

  typedef enum logic [2:0] {
    ESC_NONE    = 3'd0,
    ESC_SEEN    = 3'd1,
    ESC_CSI     = 3'd2,
    ESC_OSC     = 3'd3,
    ESC_OSC_ESC = 3'd4
  } esc_mode_e;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_APPEND        = 3'd1,
    ACT_DELETE        = 3'd2,
    ACT_CLEAR         = 3'd3,
    ACT_COMMIT        = 3'd4,
    ACT_CLEAR_APPEND  = 3'd5,
    ACT_COMMIT_APPEND = 3'd6
  } action_e;

  typedef struct packed {
    esc_mode_e        mode;
    logic [CNT_W-1:0] cnt;
    logic             ovw;
  } edit_state_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] out_char;
    logic [7:0] new_length;
  } edit_result_t;

endpackage

// ===== src/tesle_step.sv =====
module tesle_step (
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_stream_i,
  input  tesle_pkg::edit_state_t state_i,
  output tesle_pkg::edit_state_t state_o,
  output tesle_pkg::edit_result_t result_o
);

  localparam logic [tesle_pkg::CNT_W-1:0] CntFull =
    tesle_pkg::CNT_W'(tesle_pkg::LINE_COLUMNS - 1);
  localparam logic [tesle_pkg::CNT_W-1:0] CntOne = tesle_pkg::CNT_W'(1);

  tesle_pkg::edit_state_t nxt;
  tesle_pkg::action_e     act;
  logic [7:0]             ch;
  logic                   printable;

  assign printable = (data_byte_i == tesle_pkg::BYTE_TAB) ||
                     ((data_byte_i >= tesle_pkg::BYTE_SPACE) &&
                      (data_byte_i != tesle_pkg::BYTE_DEL));

  always_comb begin
    nxt = state_i;
    act = tesle_pkg::ACT_NONE;
    ch  = 8'h00;
    if (end_of_stream_i) begin
      // The escape mode is kept across a flush.
      if (state_i.cnt != '0) begin
        nxt.cnt = '0;
        nxt.ovw = 1'b0;
        act     = tesle_pkg::ACT_COMMIT;
      end
    end else begin
      case (state_i.mode)
        tesle_pkg::ESC_SEEN: begin
          if (data_byte_i == tesle_pkg::BYTE_CSI) begin
            nxt.mode = tesle_pkg::ESC_CSI;
          end else if (data_byte_i == tesle_pkg::BYTE_OSC) begin
            nxt.mode = tesle_pkg::ESC_OSC;
          end else begin
            nxt.mode = tesle_pkg::ESC_NONE;
          end
        end
        tesle_pkg::ESC_CSI: begin
          if (data_byte_i inside {[tesle_pkg::FINAL_LO:tesle_pkg::FINAL_HI]}) begin
            nxt.mode = tesle_pkg::ESC_NONE;
          end
        end
        tesle_pkg::ESC_OSC: begin
          if (data_byte_i == tesle_pkg::BYTE_BEL) begin
            nxt.mode = tesle_pkg::ESC_NONE;
          end else if (data_byte_i == tesle_pkg::BYTE_ESC) begin
            nxt.mode = tesle_pkg::ESC_OSC_ESC;
          end
        end
        tesle_pkg::ESC_OSC_ESC: begin
          if (data_byte_i == tesle_pkg::BYTE_BSL) begin
            nxt.mode = tesle_pkg::ESC_NONE;
          end else if (data_byte_i != tesle_pkg::BYTE_ESC) begin
            nxt.mode = tesle_pkg::ESC_OSC;
          end
        end
        default: begin
          // Undefined mode codes behave as no escape in progress.
          nxt.mode = tesle_pkg::ESC_NONE;
          if (data_byte_i == tesle_pkg::BYTE_ESC) begin
            nxt.mode = tesle_pkg::ESC_SEEN;
          end else if (data_byte_i == tesle_pkg::BYTE_CR) begin
            nxt.ovw = 1'b1;
          end else if (data_byte_i == tesle_pkg::BYTE_LF) begin
            nxt.ovw = 1'b0;
            if (!(state_i.ovw && state_i.cnt == '0)) begin
              nxt.cnt = '0;
              act     = tesle_pkg::ACT_COMMIT;
            end
          end else if (data_byte_i == tesle_pkg::BYTE_BS) begin
            if (state_i.ovw) begin
              nxt.cnt = '0;
              nxt.ovw = 1'b0;
              act     = tesle_pkg::ACT_CLEAR;
            end else if (state_i.cnt != '0) begin
              nxt.cnt = state_i.cnt - CntOne;
              act     = tesle_pkg::ACT_DELETE;
            end
          end else if (printable) begin
            ch      = data_byte_i;
            nxt.ovw = 1'b0;
            if (state_i.ovw) begin
              // A pending overwrite restarts the line with this character.
              nxt.cnt = CntOne;
              act     = tesle_pkg::ACT_CLEAR_APPEND;
            end else if (state_i.cnt >= CntFull) begin
              nxt.cnt = CntOne;
              act     = tesle_pkg::ACT_COMMIT_APPEND;
            end else begin
              nxt.cnt = state_i.cnt + CntOne;
              act     = tesle_pkg::ACT_APPEND;
            end
          end
        end
      endcase
    end
  end

  assign state_o             = nxt;
  assign result_o.action     = act;
  assign result_o.out_char   = ch;
  assign result_o.new_length = 8'(nxt.cnt);

endmodule

// ===== src/terminal_escape_strip_line_editor.sv =====
// Channel  | Valid        | Stall        | Payload
// input    | in_valid_i   | in_stall_o   | data_byte_i, end_of_stream_i
// output   | out_valid_o  | out_stall_i  | edit_action_o, out_char_o, new_length_o
//
// Each byte passes an input register and a result register; one byte per cycle is sustained
// while out_stall_i is low. The step logic is a single pass through tesle_step.
// Reset clears the escape mode, the line length, the overwrite flag and both valid flags.
// A stall on the output holds the result; the input register then fills and stalls upstream.
module terminal_escape_strip_line_editor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] edit_action_o,
  output logic [7:0] out_char_o,
  output logic [7:0] new_length_o
);

  // Input register stage.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eos_q;

  // Result register stage.
  logic                    out_vld_q;
  tesle_pkg::edit_result_t res_q;

  // Editor state, updated once per transaction that moves into the result register.
  tesle_pkg::edit_state_t st_q, st_d;
  tesle_pkg::edit_result_t res_d;

  logic out_free;
  logic move;
  logic in_acc;

  // The result register can load when it is empty or is being drained this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign move       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  tesle_step u_step (
    .data_byte_i     (byte_q),
    .end_of_stream_i (eos_q),
    .state_i         (st_q),
    .state_o         (st_d),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      st_q      <= '{mode: tesle_pkg::ESC_NONE, cnt: '0, ovw: 1'b0};
    end else begin
      if (out_free) begin
        out_vld_q <= move;
      end
      if (move) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign edit_action_o = res_q.action;
  assign out_char_o    = res_q.out_char;
  assign new_length_o  = res_q.new_length;

`ifndef NO_ASSERTIONS
  // The line never grows beyond its capacity less one.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cnt <= tesle_pkg::CNT_W'(tesle_pkg::LINE_COLUMNS - 1))
    else $error("line length beyond capacity");

  // A plain commit always leaves an empty line.
  a_commit_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (edit_action_o == tesle_pkg::ACT_COMMIT) |-> new_length_o == 8'h00)
    else $error("commit left a nonempty line");

  // Upstream is only stalled while a byte waits in the input register.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("stall without a waiting byte");

  // A byte taken while the pipe is free reaches the result register next cycle.
  a_move_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_vld_q)
    else $error("transaction lost between stages");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tesle_pkg::*;

  // Random traffic stops once this many transactions have been offered in total.
  localparam int unsigned ITEM_TARGET = 1060;
  // Cycles for which the receiver refuses results once, so that the pipeline backs up.
  localparam int unsigned LONG_HOLD   = 120;
  // Two register stages sit between input and output.
  localparam int unsigned LATENCY     = 2;
  localparam int unsigned MAX_REPORTS = 10;

  // Directed opening sequence: each word is {end_of_stream, data_byte}.
  localparam int unsigned DIRECTED_LEN = 31;
  localparam logic [8:0] DIRECTED [0:DIRECTED_LEN-1] = '{
    {1'b0, 8'h41}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, BYTE_DEL},
    {1'b0, BYTE_TAB}, {1'b0, BYTE_BS}, {1'b0, BYTE_CR}, {1'b0, 8'h78},
    {1'b0, BYTE_CR}, {1'b0, BYTE_BS}, {1'b0, BYTE_BS}, {1'b0, BYTE_LF},
    {1'b0, BYTE_CR}, {1'b0, BYTE_LF}, {1'b0, BYTE_ESC}, {1'b0, 8'h63},
    {1'b0, BYTE_ESC}, {1'b0, BYTE_CSI}, {1'b0, 8'h33}, {1'b0, FINAL_HI},
    {1'b0, BYTE_ESC}, {1'b0, BYTE_OSC}, {1'b0, BYTE_BEL}, {1'b0, BYTE_ESC},
    {1'b0, BYTE_OSC}, {1'b0, BYTE_ESC}, {1'b0, BYTE_ESC}, {1'b1, 8'hFF},
    {1'b0, BYTE_BSL}, {1'b0, 8'h71}, {1'b1, 8'h00}
  };

  // Mirrors the line editor: escape decoding, line length and the pending overwrite.
  // Every accepted input transaction yields exactly one expected edit.
  class edit_scoreboard;
    esc_mode_e    mode;
    int unsigned  line_len;
    bit           cr_armed;
    edit_result_t expected_edits[$];
    int unsigned  n_checked;
    int unsigned  n_errors;

    function new();
      mode      = ESC_NONE;
      line_len  = 0;
      cr_armed  = 1'b0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function int unsigned pending();
      return expected_edits.size();
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      action_e      act;
      logic [7:0]   ch;
      edit_result_t res;
      act = ACT_NONE;
      ch  = 8'h00;
      if (eos) begin
        // Flush: only a nonempty line is committed, the escape state survives.
        if (line_len > 0) begin
          line_len = 0;
          cr_armed = 1'b0;
          act      = ACT_COMMIT;
        end
      end else if (mode != ESC_NONE) begin
        // Bytes inside an escape sequence are swallowed.
        case (mode)
          ESC_SEEN: begin
            if (b == BYTE_CSI) mode = ESC_CSI;
            else if (b == BYTE_OSC) mode = ESC_OSC;
            else mode = ESC_NONE;
          end
          ESC_CSI: begin
            if (b >= FINAL_LO && b <= FINAL_HI) mode = ESC_NONE;
          end
          ESC_OSC: begin
            if (b == BYTE_BEL) mode = ESC_NONE;
            else if (b == BYTE_ESC) mode = ESC_OSC_ESC;
          end
          ESC_OSC_ESC: begin
            if (b == BYTE_BSL) mode = ESC_NONE;
            else if (b != BYTE_ESC) mode = ESC_OSC;
          end
          default: mode = ESC_NONE;
        endcase
      end else if (b == BYTE_ESC) begin
        mode = ESC_SEEN;
      end else if (b == BYTE_CR) begin
        cr_armed = 1'b1;
      end else if (b == BYTE_LF) begin
        if (cr_armed && line_len == 0) begin
          cr_armed = 1'b0;
        end else begin
          line_len = 0;
          cr_armed = 1'b0;
          act      = ACT_COMMIT;
        end
      end else if (b == BYTE_BS) begin
        if (cr_armed) begin
          line_len = 0;
          cr_armed = 1'b0;
          act      = ACT_CLEAR;
        end else if (line_len > 0) begin
          line_len--;
          act = ACT_DELETE;
        end
      end else if (b == BYTE_TAB || (b >= BYTE_SPACE && b != BYTE_DEL)) begin
        act = ACT_APPEND;
        if (cr_armed) begin
          line_len = 0;
          cr_armed = 1'b0;
          act      = ACT_CLEAR_APPEND;
        end
        if (line_len >= LINE_COLUMNS - 1) begin
          line_len = 0;
          cr_armed = 1'b0;
          act      = ACT_COMMIT_APPEND;
        end
        line_len++;
        ch = b;
      end
      res.action     = act;
      res.out_char   = ch;
      res.new_length = 8'(line_len);
      expected_edits.push_back(res);
    endfunction

    function void check_edit(logic [2:0] act, logic [7:0] ch, logic [7:0] len);
      edit_result_t exp_edit;
      n_checked++;
      if (expected_edits.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected edit: action %0d char %02h length %0d", act, ch, len);
        return;
      end
      exp_edit = expected_edits.pop_front();
      if (act !== exp_edit.action || ch !== exp_edit.out_char ||
          len !== exp_edit.new_length) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display(
            "edit mismatch #%0d: expected action %0d char %02h length %0d, got %0d %02h %0d",
            n_checked, exp_edit.action, exp_edit.out_char, exp_edit.new_length,
            act, ch, len);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       end_of_stream_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] edit_action_o;
  logic [7:0] out_char_o;
  logic [7:0] new_length_o;

  edit_scoreboard sb = new();
  int unsigned    items_sent;
  int unsigned    quiet_left;

  terminal_escape_strip_line_editor u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edit_action_o   (edit_action_o),
    .out_char_o      (out_char_o),
    .new_length_o    (new_length_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hard stop, far beyond the slowest legal run with the longest gaps and stalls.
  initial begin
    #10_000_000;
    $display("terminal_escape_strip_line_editor test failed");
    $finish;
  end

  // Printable text: mostly ASCII, a fair share of high bytes and the odd TAB.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return BYTE_TAB;
    if (r < 4) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // The sender idles for a random number of cycles before each transaction: usually none,
  // sometimes a few, occasionally a long gap. Quiet stretches send back to back.
  function automatic int unsigned pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one byte and holds it steady until the block takes it. The valid line is only
  // lowered when a gap follows, so it never sees two assignments in the same time step.
  task automatic send_byte(logic [7:0] b, logic eos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= eos;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_byte(b, eos);
    items_sent++;
  endtask

  // Stops offering transactions until every expected edit has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Output side: a result transaction is taken at an edge where valid is high and stall low.
  // Sampling in the active region sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_edit(edit_action_o, out_char_o, new_length_o);
  end

  // Receiver back-pressure. Once, after a few hundred results, it holds off for a long
  // stretch so that both register stages fill and the input stalls; otherwise it alternates
  // between runs of acceptance (some of them long) and short or occasionally long stalls.
  initial begin
    int          r;
    int unsigned run;
    int unsigned hold;
    bit          held_once;
    out_stall_i = 1'b0;
    held_once   = 1'b0;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (!held_once && sb.n_checked >= 300) begin
        held_once = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      r   = $urandom_range(0, 99);
      run = (r < 5) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk);
      r    = $urandom_range(0, 99);
      hold = (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  // Stimulus: reset, a directed pass over the corner cases, then random traffic built
  // mostly from well-formed text, escape sequences and line controls, with some noise.
  initial begin
    int          r;
    int unsigned n;
    int unsigned next_long_line;
    bit          paused;
    logic [7:0]  b;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_stream_i = 1'b0;
    items_sent      = 0;
    quiet_left      = 0;
    next_long_line  = 300;
    paused          = 1'b0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Appends of a plain and a high byte, ignored controls, delete, the carriage return cases,
    // line feed on an empty line, all three escape forms and flushes inside and outside one.
    for (int k = 0; k < DIRECTED_LEN; k++)
      send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      // After 600 transactions, the sender pauses until every result is back.
      if (!paused && items_sent >= 600) begin
        paused = 1'b1;
        wait_drained();
      end
      if (items_sent >= next_long_line) begin
        // A run of text about as long as a line or longer exercises the commit-then-append path.
        next_long_line += 400;
        n = $urandom_range(LINE_COLUMNS - 1, LINE_COLUMNS + 44);
        repeat (n) send_byte(pick_text_byte(), 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          n = $urandom_range(1, 24);
          repeat (n) send_byte(pick_text_byte(), 1'b0);
        end else if (r < 50) begin
          // Control sequence: parameter and intermediate bytes, then a final byte.
          send_byte(BYTE_ESC, 1'b0);
          send_byte(BYTE_CSI, 1'b0);
          n = $urandom_range(0, 4);
          repeat (n) send_byte(8'($urandom_range(8'h20, 8'h3F)), 1'b0);
          send_byte(8'($urandom_range(FINAL_LO, FINAL_HI)), 1'b0);
        end else if (r < 58) begin
          // Operating system command, closed by BEL or by ESC backslash.
          send_byte(BYTE_ESC, 1'b0);
          send_byte(BYTE_OSC, 1'b0);
          n = $urandom_range(0, 10);
          repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
          r = $urandom_range(0, 2);
          if (r == 0) begin
            send_byte(BYTE_BEL, 1'b0);
          end else begin
            send_byte(BYTE_ESC, 1'b0);
            if (r == 2) send_byte(BYTE_ESC, 1'b0);
            send_byte(BYTE_BSL, 1'b0);
          end
        end else if (r < 63) begin
          send_byte(BYTE_ESC, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 78) begin
          r = $urandom_range(0, 3);
          case (r)
            0: send_byte(BYTE_CR, 1'b0);
            1: send_byte(BYTE_LF, 1'b0);
            2: begin
              send_byte(BYTE_CR, 1'b0);
              send_byte(BYTE_LF, 1'b0);
            end
            default: begin
              send_byte(BYTE_CR, 1'b0);
              send_byte(pick_text_byte(), 1'b0);
            end
          endcase
        end else if (r < 85) begin
          n = $urandom_range(1, 5);
          repeat (n) send_byte(BYTE_BS, 1'b0);
        end else if (r < 90) begin
          send_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          // Noise: any byte, now and then flagged as end of stream.
          b = 8'($urandom_range(0, 255));
          send_byte(b, ($urandom_range(0, 7) == 0));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    // A few more cycles so that any stray result still in flight gets caught.
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("terminal_escape_strip_line_editor test passed");
    else
      $display("terminal_escape_strip_line_editor test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tesle_pkg.sv
src/tesle_step.sv
src/terminal_escape_strip_line_editor.sv
tb/tb.sv
